@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// No dependencies; take it by include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/fsp_pkg.sv @@
// Shared constants and types of the first-seen palette quantizer.
// No dependencies; used by the interfaces, the top level and the checker.
package fsp_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int CH_W       = 5;
  localparam int CELL_W     = 3 * CH_W;
  localparam int WORD_W     = 15;
  localparam int DIST_W     = 7;
  localparam int PIX_W      = 8;
  localparam int USED_W     = 9;
  localparam int ENTRY_W    = 8;
  localparam int COLOUR_W   = 8;
  localparam int KIND_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NO_OP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP_CHK,
    ST_SEARCH,
    ST_MAP_WR,
    ST_PAL_RD,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/fsp_stream_if.sv @@
// Valid/ready channel interfaces for the input and result items.
// Depends on fsp_pkg for the field widths.
interface fsp_in_if;
  import fsp_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [COLOUR_W-1:0] red;
  logic [COLOUR_W-1:0] green;
  logic [COLOUR_W-1:0] blue;
  logic [ENTRY_W-1:0]  entry_index;

  modport source(output valid, kind, red, green, blue, entry_index, input ready);
  modport sink(input valid, kind, red, green, blue, entry_index, output ready);
endinterface

interface fsp_out_if;
  import fsp_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_index;
  logic [WORD_W-1:0] palette_word;
  logic [USED_W-1:0] used_entries;

  modport source(output valid, pixel_index, palette_word, used_entries, input ready);
  modport sink(input valid, pixel_index, palette_word, used_entries, output ready);
endinterface

@@ hw/rtl/first_seen_palette_quantizer.sv @@
// First-seen palette quantizer: maps 8-bit RGB pixels onto a palette that is built per frame.
// Depends on fsp_pkg, fsp_stream_if and fsp_ram.
//
// One item is taken at a time and each gives exactly one result. A pixel whose 5-5-5 cell is
// already mapped, or which still finds a free palette slot, reads the cell map, then decides
// and writes back. A palette read goes through the palette RAM's registered read port, and a
// no-op item is answered from the idle state. A new colour that meets a full palette is
// searched by one shared distance unit that walks the palette RAM one entry a cycle. A start
// item sweeps the 32768-entry cell map one entry a cycle; the same sweep runs after reset, and
// no item is taken until it has finished. A finished result waits in an output register, so
// the next item can be taken while it is still pending.
module first_seen_palette_quantizer #(
  parameter int PALETTE_ENTRIES = fsp_pkg::PALETTE_ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  fsp_in_if.sink     in_ch,
  fsp_out_if.source  out_ch
);
  import fsp_pkg::*;

  localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
  localparam int SLOT_W = $clog2(PALETTE_ENTRIES + 1);
  localparam int MAP_W  = IDX_W + 1;
  localparam int CELLS  = 1 << CELL_W;

  function automatic logic [CH_W-1:0] ch_dist(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  state_t              state_r, state_nxt;
  logic [CELL_W-1:0]   clr_r, clr_nxt;
  logic                clr_reply_r, clr_reply_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [CH_W-1:0]     red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic [ENTRY_W-1:0]  entry_r, entry_nxt;
  logic [SLOT_W-1:0]   iss_r, iss_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]    best_r, best_nxt;
  logic [DIST_W-1:0]   best_d_r, best_d_nxt;
  logic [PIX_W-1:0]    pix_r, pix_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]    out_pix_r, out_pix_nxt;
  logic [WORD_W-1:0]   out_word_r, out_word_nxt;
  logic [USED_W-1:0]   out_used_r, out_used_nxt;

  logic                map_we;
  logic [CELL_W-1:0]   map_waddr, map_raddr;
  logic [MAP_W-1:0]    map_wdata, map_rdata;
  logic                pal_we;
  logic [IDX_W-1:0]    pal_waddr, pal_raddr;
  logic [WORD_W-1:0]   pal_wdata, pal_rdata;

  logic                in_acc;
  logic [CELL_W-1:0]   cell_q;
  logic                map_hit, room, out_free, iss_end, clr_end;
  logic [DIST_W-1:0]   dist_sum;
  logic                closer;
  logic                res_done;
  logic [PIX_W-1:0]    res_pix;
  logic [WORD_W-1:0]   res_word;

  fsp_ram #(.WIDTH(MAP_W), .DEPTH(CELLS)) u_cell_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  fsp_ram #(.WIDTH(WORD_W), .DEPTH(PALETTE_ENTRIES)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cell_q      = {blue_r, green_r, red_r};
  assign map_hit     = map_rdata[MAP_W-1];
  assign room        = (slot_r != SLOT_W'(PALETTE_ENTRIES));
  assign out_free    = !out_valid_r || out_ch.ready;
  assign iss_end     = (iss_r == SLOT_W'(PALETTE_ENTRIES));
  assign clr_end     = &clr_r;

  // The shared distance unit: Manhattan distance of the held pixel to the word just read.
  assign dist_sum = DIST_W'(ch_dist(red_r,   pal_rdata[CH_W-1:0]))
                  + DIST_W'(ch_dist(green_r, pal_rdata[2*CH_W-1:CH_W]))
                  + DIST_W'(ch_dist(blue_r,  pal_rdata[3*CH_W-1:2*CH_W]));
  assign closer = cmp_v_r && (dist_sum < best_d_r);

  always_comb begin
    case (state_r)
      ST_CLEAR:   res_done = clr_end && clr_reply_r;
      ST_IDLE:    res_done = in_ch.valid && (kind_t'(in_ch.kind) == KIND_NO_OP);
      ST_MAP_CHK: res_done = map_hit || room;
      ST_MAP_WR:  res_done = 1'b1;
      ST_PAL_RD:  res_done = 1'b1;
      ST_DONE:    res_done = 1'b1;
      default:    res_done = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_end && !clr_reply_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (kind_t'(in_ch.kind))
            KIND_START: state_nxt = ST_CLEAR;
            KIND_PIXEL: state_nxt = ST_MAP_CHK;
            KIND_READ:  state_nxt = ST_PAL_RD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MAP_CHK: begin
        if (!res_done) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (iss_end) begin
          state_nxt = ST_MAP_WR;
        end
      end
      default: state_nxt = state_r;
    endcase
    // A finished item either hands its result straight over or parks it.
    if (res_done) begin
      state_nxt = out_free ? ST_IDLE : ST_DONE;
    end
  end

  // Datapath and memory controls
  always_comb begin
    clr_nxt       = clr_r;
    clr_reply_nxt = clr_reply_r;
    slot_nxt      = slot_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    entry_nxt     = entry_r;
    iss_nxt       = iss_r;
    cmp_v_nxt     = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    best_nxt      = best_r;
    best_d_nxt    = best_d_r;
    pix_nxt       = pix_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_word_nxt  = out_word_r;
    out_used_nxt  = out_used_r;
    res_pix       = '0;
    res_word      = '0;

    map_we    = 1'b0;
    map_waddr = cell_q;
    map_wdata = {1'b1, slot_r[IDX_W-1:0]};
    map_raddr = {in_ch.blue[COLOUR_W-1 -: CH_W], in_ch.green[COLOUR_W-1 -: CH_W],
                 in_ch.red[COLOUR_W-1 -: CH_W]};
    pal_we    = 1'b0;
    pal_waddr = slot_r[IDX_W-1:0];
    pal_wdata = cell_q;
    pal_raddr = (state_r == ST_SEARCH) ? iss_r[IDX_W-1:0] : in_ch.entry_index[IDX_W-1:0];

    case (state_r)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        map_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_acc) begin
          red_nxt   = in_ch.red[COLOUR_W-1 -: CH_W];
          green_nxt = in_ch.green[COLOUR_W-1 -: CH_W];
          blue_nxt  = in_ch.blue[COLOUR_W-1 -: CH_W];
          entry_nxt = in_ch.entry_index;
          if (kind_t'(in_ch.kind) == KIND_START) begin
            clr_nxt       = '0;
            clr_reply_nxt = 1'b1;
            slot_nxt      = '0;
          end
        end
      end
      ST_MAP_CHK: begin
        if (map_hit) begin
          res_pix = PIX_W'(map_rdata[IDX_W-1:0]);
        end else if (room) begin
          pal_we   = 1'b1;
          map_we   = 1'b1;
          slot_nxt = slot_r + 1'b1;
          res_pix  = PIX_W'(slot_r);
        end else begin
          iss_nxt    = '0;
          best_nxt   = '0;
          best_d_nxt = '1;
        end
      end
      ST_SEARCH: begin
        // Reads run one entry ahead of the compare because of the registered read.
        if (!iss_end) begin
          iss_nxt     = iss_r + 1'b1;
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = iss_r[IDX_W-1:0];
        end
        if (closer) begin
          best_nxt   = cmp_idx_r;
          best_d_nxt = dist_sum;
        end
      end
      ST_MAP_WR: begin
        map_we    = 1'b1;
        map_wdata = {1'b1, best_r};
        res_pix   = PIX_W'(best_r);
      end
      ST_PAL_RD: begin
        if (USED_W'(entry_r) < USED_W'(slot_r)) begin
          res_word = pal_rdata;
        end
      end
      ST_DONE: begin
        res_pix  = pix_r;
        res_word = word_r;
      end
      default: begin
        res_pix = '0;
      end
    endcase

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_done) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_pix_nxt   = res_pix;
        out_word_nxt  = res_word;
        out_used_nxt  = USED_W'(slot_nxt);
      end else begin
        pix_nxt  = res_pix;
        word_nxt = res_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      clr_reply_r <= 1'b0;
      slot_r      <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_reply_r <= clr_reply_nxt;
      slot_r      <= slot_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r      <= red_nxt;
    green_r    <= green_nxt;
    blue_r     <= blue_nxt;
    entry_r    <= entry_nxt;
    iss_r      <= iss_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_r     <= best_nxt;
    best_d_r   <= best_d_nxt;
    pix_r      <= pix_nxt;
    word_r     <= word_nxt;
    out_pix_r  <= out_pix_nxt;
    out_word_r <= out_word_nxt;
    out_used_r <= out_used_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_index  = out_pix_r;
  assign out_ch.palette_word = out_word_r;
  assign out_ch.used_entries = out_used_r;

endmodule

@@ hw/rtl/fsp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/fsp_checker.sv @@
// Port-level checks of the first-seen palette quantizer, bound to its top level.
// Depends on fsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsp_checker #(
  parameter int PALETTE_ENTRIES = fsp_pkg::PALETTE_ENTRIES_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [fsp_pkg::PIX_W-1:0]  pixel_index,
  input logic [fsp_pkg::WORD_W-1:0] palette_word,
  input logic [fsp_pkg::USED_W-1:0] used_entries
);
  import fsp_pkg::*;

  // The cell map is being cleared straight after reset, so nothing moves.
  `ASSERT_IMP(a_quiet_after_reset, clk, rst_n, !$past(rst_n), !in_ready && !out_valid)

  // A stalled result transfer keeps its payload.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pixel_index) && $stable(palette_word) && $stable(used_entries))

  // The fill count never passes the palette size.
  `ASSERT_IMP(a_used_bound, clk, rst_n, out_valid, used_entries <= USED_W'(PALETTE_ENTRIES))

  // A nonzero pixel index points at an allocated slot, and the palette word is then zero.
  `ASSERT_IMP(a_index_allocated, clk, rst_n, out_valid && (pixel_index != '0), (USED_W'(pixel_index) < used_entries) && (palette_word == '0))

endmodule

bind first_seen_palette_quantizer fsp_checker #(
  .PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_fsp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pixel_index  (out_ch.pixel_index),
  .palette_word (out_ch.palette_word),
  .used_entries (out_ch.used_entries)
);

@@ sim/first_seen_palette_quantizer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for first_seen_palette_quantizer: directed frames, then random frames.
// Depends on fsp_pkg, the fsp_in_if/fsp_out_if channel interfaces and the block's RTL.
module first_seen_palette_quantizer_tb;
  import fsp_pkg::*;

  localparam int          PAL_SIZE     = PALETTE_ENTRIES_DEF;
  localparam int          CELL_COUNT   = 1 << CELL_W;
  localparam int          DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_index;
    logic [WORD_W-1:0] palette_word;
    logic [USED_W-1:0] used_entries;
  } quant_result_t;

  // Tracks the palette built for the current frame and holds the results still owed by the block.
  class palette_tracker;
    bit [8:0]        cell_map [CELL_COUNT];
    bit [WORD_W-1:0] palette_words [PAL_SIZE];
    bit              entry_written [PAL_SIZE];
    int unsigned     slot_count;
    quant_result_t   pending_results [$];
    int              error_count;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
    endtask

    function int unsigned chan_dist(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Closest stored colour by Manhattan distance; the strict compare keeps the lowest index.
    function int unsigned nearest_entry(logic [4:0] r, logic [4:0] g, logic [4:0] b);
      int unsigned best;
      int unsigned best_dist;
      int unsigned man_dist;
      best = 0;
      best_dist = 32'hFFFF;
      for (int p = 0; p < PAL_SIZE; p++) begin
        man_dist = chan_dist(32'(r), 32'(palette_words[p][4:0]))
                 + chan_dist(32'(g), 32'(palette_words[p][9:5]))
                 + chan_dist(32'(b), 32'(palette_words[p][14:10]));
        if (man_dist < best_dist) begin
          best_dist = man_dist;
          best = p;
        end
      end
      return best;
    endfunction

    function void note_item(kind_t kind, logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                            logic [7:0] entry);
      logic [CELL_W-1:0] cell_idx;
      int unsigned       idx;
      quant_result_t     res;
      res = '0;
      case (kind)
        KIND_START: begin
          foreach (cell_map[i]) cell_map[i] = '0;
          slot_count = 0;
        end
        KIND_PIXEL: begin
          cell_idx = {blue[7:3], green[7:3], red[7:3]};
          if (!cell_map[cell_idx][8]) begin
            if (slot_count < PAL_SIZE) begin
              idx = slot_count;
              palette_words[idx] = cell_idx;
              entry_written[idx] = 1'b1;
              slot_count++;
            end else begin
              idx = nearest_entry(red[7:3], green[7:3], blue[7:3]);
            end
            cell_map[cell_idx] = {1'b1, idx[7:0]};
          end
          res.pixel_index = cell_map[cell_idx][7:0];
        end
        KIND_READ: begin
          if (entry < slot_count) res.palette_word = palette_words[entry];
        end
        KIND_NO_OP: ;
        default: ;
      endcase
      res.used_entries = slot_count[USED_W-1:0];
      pending_results.push_back(res);
    endfunction

    task check_result(logic [PIX_W-1:0] pix, logic [WORD_W-1:0] word, logic [USED_W-1:0] used);
      quant_result_t want;
      if (pending_results.size() == 0) begin
        report("result transfer with no item outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (pix !== want.pixel_index)
        report($sformatf("pixel_index %0d, expected %0d", pix, want.pixel_index));
      if (word !== want.palette_word)
        report($sformatf("palette_word %h, expected %h", word, want.palette_word));
      if (used !== want.used_entries)
        report($sformatf("used_entries %0d, expected %0d", used, want.used_entries));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int unsigned cycle_count;
  bit src_quiet;
  bit sink_quiet;
  logic [23:0] frame_colours [$];
  palette_tracker tracker = new;

  fsp_in_if  in_ch ();
  fsp_out_if out_ch ();

  first_seen_palette_quantizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Every so often a side switches into or out of a stretch without idle cycles.
  function automatic int unsigned draw_gap(inout bit quiet);
    if ($urandom_range(0, 31) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(kind_t kind, logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                           logic [7:0] entry);
    int unsigned gap;
    gap = draw_gap(src_quiet);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.kind        <= kind;
    in_ch.red         <= red;
    in_ch.green       <= green;
    in_ch.blue        <= blue;
    in_ch.entry_index <= entry;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    tracker.note_item(kind, red, green, blue, entry);
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    frame_colours.push_back({red, green, blue});
    send_item(KIND_PIXEL, red, green, blue, rnd8());
  endtask

  task automatic random_item(int unsigned new_pct, int unsigned repeat_pct,
                             int unsigned read_pct);
    int unsigned roll;
    logic [23:0] colour;
    logic [7:0]  entry;
    int          tries;
    roll = $urandom_range(0, 99);
    if (roll < new_pct || (roll < new_pct + repeat_pct && frame_colours.size() == 0)) begin
      send_pixel(rnd8(), rnd8(), rnd8());
    end else if (roll < new_pct + repeat_pct) begin
      // Same cell as an earlier pixel of this frame, with fresh truncated bits.
      colour = frame_colours[$urandom_range(0, frame_colours.size() - 1)];
      send_pixel(colour[23:16] ^ (rnd8() & 8'h07), colour[15:8] ^ (rnd8() & 8'h07),
                 colour[7:0] ^ (rnd8() & 8'h07));
    end else if (roll < new_pct + repeat_pct + read_pct) begin
      // Entries that have held a colour at some point are preferred; entry 0 stands in if none is found.
      entry = rnd8();
      tries = 0;
      while (!tracker.entry_written[entry] && tries < 16) begin
        entry = rnd8();
        tries++;
      end
      if (!tracker.entry_written[entry]) entry = 8'd0;
      send_item(KIND_READ, rnd8(), rnd8(), rnd8(), entry);
    end else begin
      send_item(KIND_NO_OP, rnd8(), rnd8(), rnd8(), rnd8());
    end
  endtask

  // A frame may first fill the palette, so that later new colours go through the search.
  task automatic random_frame(int unsigned tail_items, bit fill_palette);
    send_item(KIND_START, rnd8(), rnd8(), rnd8(), rnd8());
    frame_colours.delete();
    while (fill_palette && tracker.slot_count < PAL_SIZE) random_item(85, 8, 5);
    repeat (tail_items) random_item(35, 35, 22);
  endtask

  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = draw_gap(sink_quiet);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_result(out_ch.pixel_index, out_ch.palette_word, out_ch.used_entries);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_START;
    in_ch.red         = '0;
    in_ch.green       = '0;
    in_ch.blue        = '0;
    in_ch.entry_index = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The first pixels run on the state left by reset, before any start item.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd7, 8'd7, 8'd7);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd64, 8'd32);
    send_pixel(8'd248, 8'd7, 8'd0);
    send_item(KIND_READ, rnd8(), rnd8(), rnd8(), 8'd0);
    send_item(KIND_READ, rnd8(), rnd8(), rnd8(), 8'd1);
    send_item(KIND_READ, rnd8(), rnd8(), rnd8(), 8'd5);
    send_item(KIND_NO_OP, 8'd255, 8'd255, 8'd255, 8'd255);
    send_item(KIND_START, 8'd255, 8'd255, 8'd255, 8'd255);
    // Slots written in the previous frame now read as unused.
    send_item(KIND_READ, rnd8(), rnd8(), rnd8(), 8'd1);
    send_item(KIND_NO_OP, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_item(KIND_READ, rnd8(), rnd8(), rnd8(), 8'd0);
    send_item(KIND_READ, rnd8(), rnd8(), rnd8(), 8'd3);
    send_item(KIND_START, 8'd0, 8'd0, 8'd0, 8'd0);

    random_frame(70, 1'b1);
    repeat (3) random_frame(70, 1'b0);

    in_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ first_seen_palette_quantizer.f @@
+incdir+hw/rtl
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_stream_if.sv
hw/rtl/fsp_ram.sv
hw/rtl/first_seen_palette_quantizer.sv
hw/rtl/fsp_checker.sv
sim/first_seen_palette_quantizer_tb.sv
